// ===== design/ntc_thermistor_temperature_monitor_unit_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef NTC_THERMISTOR_TEMPERATURE_MONITOR_UNIT_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and quiet during reset.
`define NTC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk_i and quiet during reset.
`define NTC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ntcmon_pkg.sv =====
package ntcmon_pkg;

  localparam int unsigned AdcFullScale = 65535;
  localparam int unsigned ZeroPointCk  = 22315;
  localparam logic [15:0] FailedSample = 16'hFFFF;
  localparam logic [31:0] Ln2Q32       = 32'd2977044472;

  localparam int unsigned DivDw = 56;
  localparam int unsigned DivVw = 44;
  localparam int unsigned DivCw = 6;

  localparam logic [6:0]  RstFilterLength = 7'd16;
  localparam logic [19:0] RstDividerOhms  = 20'd10000;
  localparam logic [19:0] RstResFloor     = 20'd300;
  localparam logic [19:0] RstResCeiling   = 20'd400000;
  localparam logic [13:0] RstBetaKelvin   = 14'd3435;
  localparam logic [19:0] RstNominalOhms  = 20'd10000;
  localparam logic [15:0] RstNominalCk    = 16'd29815;
  localparam logic [7:0]  RstOverLimit    = 8'd150;

  typedef enum logic [2:0] {
    RegFilterLength = 3'd0,
    RegDividerOhms  = 3'd1,
    RegResFloor     = 3'd2,
    RegResCeiling   = 3'd3,
    RegBetaKelvin   = 3'd4,
    RegNominalOhms  = 3'd5,
    RegNominalCk    = 3'd6,
    RegOverLimit    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [DivCw-1:0] steps;
  } div_ctl_t;

endpackage

// ===== design/ntcmon_ram.sv =====
module ntcmon_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ntcmon_div.sv =====
module ntcmon_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ntcmon_pkg::div_ctl_t            ctl_i,
  input  logic [ntcmon_pkg::DivDw-1:0]    dividend_i,
  input  logic [ntcmon_pkg::DivVw-1:0]    divisor_i,
  output logic                            done_o,
  output logic [ntcmon_pkg::DivDw-1:0]    quotient_o
);

  localparam int unsigned Dw = ntcmon_pkg::DivDw;
  localparam int unsigned Vw = ntcmon_pkg::DivVw;
  localparam int unsigned Cw = ntcmon_pkg::DivCw;

  logic          run_q;
  logic          done_q;
  logic [Cw-1:0] cnt_q;
  logic [Vw-1:0] rem_q, rem_d;
  logic [Dw-1:0] quo_q, quo_d;
  logic [Vw-1:0] den_q;
  logic [Vw:0]   trial;
  logic [Vw:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[Dw-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[Vw-1:0] : trial[Vw-1:0];
    quo_d = {quo_q[Dw-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ctl_i.steps;
    end else if (run_q) begin
      cnt_q <= cnt_q - Cw'(1);
      if (cnt_q == Cw'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/ntcmon_ln.sv =====
module ntcmon_ln (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] x_i,
  output logic        done_o,
  output logic [19:0] ln_o
);

  typedef enum logic [1:0] {
    LnIdle,
    LnNorm,
    LnSquare,
    LnScale
  } ln_state_e;

  ln_state_e   state_q;
  logic        done_q;
  logic [19:0] v_q;
  logic [4:0]  e_q;
  logic [30:0] m_q;
  logic [15:0] frac_q;
  logic [3:0]  k_q;
  logic [19:0] ln_q;
  logic [61:0] sq;
  logic [52:0] scaled;

  assign sq     = m_q * m_q;
  assign scaled = 53'({e_q, frac_q}) * 53'(ntcmon_pkg::Ln2Q32) + 53'(64'h8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LnIdle;
      done_q  <= 1'b0;
      v_q     <= '0;
      e_q     <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      k_q     <= '0;
      ln_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        LnIdle: begin
          if (start_i) begin
            v_q     <= x_i;
            e_q     <= 5'd19;
            frac_q  <= '0;
            k_q     <= '0;
            state_q <= LnNorm;
          end
        end
        LnNorm: begin
          if (v_q[19]) begin
            m_q     <= {v_q, 11'b0};
            state_q <= LnSquare;
          end else begin
            v_q <= {v_q[18:0], 1'b0};
            e_q <= e_q - 5'd1;
          end
        end
        LnSquare: begin
          if (sq[61]) begin
            m_q    <= sq[61:31];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q    <= sq[60:30];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            state_q <= LnScale;
          end
        end
        LnScale: begin
          ln_q    <= scaled[51:32];
          done_q  <= 1'b1;
          state_q <= LnIdle;
        end
        default: state_q <= LnIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign ln_o   = ln_q;

endmodule

// ===== design/ntc_thermistor_temperature_monitor_unit.sv =====
// Channel  Direction  Signals                                        Beat
// in       input      in_valid_i, in_ready_o, sample_i               one ADC sample
// out      output     out_valid_o, out_ready_i, average_sample_o,    one result
//                     resistance_ohms_o, temperature_o, over_temp_o
// cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i,         one register write
//                     cfg_data_i
//
// After reset every slot of the ring memory is cleared before in_ready_o rises.
// A sample passes through one ring write, a sum sweep of filter_length + 1 reads, up to
// three passes of the shared restoring divider (22 steps at the default MAX_TAPS, 36 and
// 53 steps) and two passes of the log unit.
// A failed conversion is taken and gives no beat.
// A stalled result waits in the output register while the next sample is taken.
module ntc_thermistor_temperature_monitor_unit #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] average_sample_o,
  output logic [19:0] resistance_ohms_o,
  output logic [7:0]  temperature_o,
  output logic        over_temp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  localparam int unsigned SlotW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned LenW  = $clog2(MAX_TAPS + 1);
  localparam int unsigned SumW  = 16 + SlotW;
  localparam int unsigned CmpW  = SlotW + LenW;
  localparam int unsigned Dw    = ntcmon_pkg::DivDw;
  localparam int unsigned Vw    = ntcmon_pkg::DivVw;
  localparam int unsigned Cw    = ntcmon_pkg::DivCw;
  localparam logic [Cw-1:0] AvgSteps  = Cw'(SumW);
  localparam logic [Cw-1:0] ResSteps  = Cw'(36);
  localparam logic [Cw-1:0] TempSteps = Cw'(53);

  typedef enum logic [4:0] {
    StClear,
    StIdle,
    StWrite,
    StSum,
    StAvgDiv,
    StRes,
    StResDiv,
    StClamp,
    StLnR,
    StLnR0,
    StFx1,
    StFx2,
    StFx3,
    StFx4,
    StFx5,
    StTDiv,
    StFin
  } state_e;

  logic [6:0]  fl_q;
  logic [19:0] divr_q;
  logic [19:0] rfloor_q;
  logic [19:0] rceil_q;
  logic [13:0] beta_q;
  logic [19:0] rnom_q;
  logic [15:0] tnom_q;
  logic [7:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q     <= ntcmon_pkg::RstFilterLength;
      divr_q   <= ntcmon_pkg::RstDividerOhms;
      rfloor_q <= ntcmon_pkg::RstResFloor;
      rceil_q  <= ntcmon_pkg::RstResCeiling;
      beta_q   <= ntcmon_pkg::RstBetaKelvin;
      rnom_q   <= ntcmon_pkg::RstNominalOhms;
      tnom_q   <= ntcmon_pkg::RstNominalCk;
      limit_q  <= ntcmon_pkg::RstOverLimit;
    end else if (cfg_valid_i) begin
      unique case (ntcmon_pkg::cfg_reg_e'(cfg_index_i))
        ntcmon_pkg::RegFilterLength: fl_q     <= cfg_data_i[6:0];
        ntcmon_pkg::RegDividerOhms:  divr_q   <= cfg_data_i;
        ntcmon_pkg::RegResFloor:     rfloor_q <= cfg_data_i;
        ntcmon_pkg::RegResCeiling:   rceil_q  <= cfg_data_i;
        ntcmon_pkg::RegBetaKelvin:   beta_q   <= cfg_data_i[13:0];
        ntcmon_pkg::RegNominalOhms:  rnom_q   <= cfg_data_i;
        ntcmon_pkg::RegNominalCk:    tnom_q   <= cfg_data_i[15:0];
        ntcmon_pkg::RegOverLimit:    limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  state_e             state_q;
  logic [LenW-1:0]    cnt_q;
  logic [LenW-1:0]    len_q, len_d;
  logic [SlotW-1:0]   slot_q, slot_nxt;
  logic [15:0]        sample_q;
  logic [SumW-1:0]    sum_q;
  logic [15:0]        avg_q;
  logic [35:0]        rawp_q;
  logic [35:0]        raw_q;
  logic [19:0]        res_q;
  logic [19:0]        lnr_q;
  logic signed [20:0] d_q;
  logic [20:0]        b100_q;
  logic [36:0]        numa_q;
  logic signed [37:0] cd_q;
  logic [52:0]        num_q;
  logic signed [38:0] den_q;
  logic [52:0]        zd_q;
  logic signed [53:0] q_q;
  logic [42:0]        fifty_q;
  logic [43:0]        hund_q;
  logic [52:0]        tdvd_q;
  logic [7:0]         tmp_q;
  logic               div_start_q;
  logic               ln_start_q;
  logic               out_valid_q;
  logic [15:0]        out_avg_q;
  logic [19:0]        out_res_q;
  logic [7:0]         out_tmp_q;
  logic               out_over_q;

  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr;
  logic [15:0]        ram_wdata;
  logic [15:0]        ram_rdata;

  ntcmon_pkg::div_ctl_t div_ctl;
  logic [Dw-1:0]      div_dividend;
  logic [Vw-1:0]      div_divisor;
  logic               div_done;
  logic [Dw-1:0]      div_quo;

  logic [19:0]        ln_x;
  logic               ln_done;
  logic [19:0]        ln_res;
  logic [19:0]        r0;
  logic [35:0]        clamp_hi, clamp_lo;
  logic [19:0]        clamp_res;

  always_comb begin
    if (fl_q == '0) begin
      len_d = LenW'(1);
    end else if ({2'b00, fl_q} > 9'(MAX_TAPS)) begin
      len_d = LenW'(MAX_TAPS);
    end else begin
      len_d = LenW'(fl_q);
    end
  end

  assign slot_nxt = (CmpW'(slot_q) < (CmpW'(len_q) - CmpW'(1))) ? slot_q + SlotW'(1) : '0;

  assign ram_we    = (state_q == StClear) || (state_q == StWrite);
  assign ram_waddr = (state_q == StClear) ? cnt_q[SlotW-1:0] : slot_q;
  assign ram_wdata = (state_q == StClear) ? '0 : sample_q;

  ntcmon_ram #(
    .Width (16),
    .Depth (MAX_TAPS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[SlotW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    div_ctl.start = div_start_q;
    case (state_q)
      StAvgDiv: begin
        div_ctl.steps = AvgSteps;
        div_dividend  = {sum_q, {(Dw - SumW){1'b0}}};
        div_divisor   = Vw'(len_q);
      end
      StResDiv: begin
        div_ctl.steps = ResSteps;
        div_dividend  = {rawp_q, {(Dw - 36){1'b0}}};
        div_divisor   = Vw'(avg_q);
      end
      default: begin
        div_ctl.steps = TempSteps;
        div_dividend  = {tdvd_q, {(Dw - 53){1'b0}}};
        div_divisor   = hund_q;
      end
    endcase
  end

  ntcmon_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign r0   = (rnom_q == '0) ? 20'd1 : rnom_q;
  assign ln_x = (state_q == StLnR0) ? r0 : res_q;

  ntcmon_ln u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ln_start_q),
    .x_i     (ln_x),
    .done_o  (ln_done),
    .ln_o    (ln_res)
  );

  always_comb begin
    clamp_hi  = (raw_q > 36'(rceil_q)) ? 36'(rceil_q) : raw_q;
    clamp_lo  = (clamp_hi < 36'(rfloor_q)) ? 36'(rfloor_q) : clamp_hi;
    clamp_res = (clamp_lo == '0) ? 20'd1 : clamp_lo[19:0];
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      len_q       <= '0;
      slot_q      <= '0;
      sample_q    <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      rawp_q      <= '0;
      raw_q       <= '0;
      res_q       <= '0;
      lnr_q       <= '0;
      d_q         <= '0;
      b100_q      <= '0;
      numa_q      <= '0;
      cd_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      zd_q        <= '0;
      q_q         <= '0;
      fifty_q     <= '0;
      hund_q      <= '0;
      tdvd_q      <= '0;
      tmp_q       <= '0;
      div_start_q <= 1'b0;
      ln_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_res_q   <= '0;
      out_tmp_q   <= '0;
      out_over_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      ln_start_q  <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          if (cnt_q == LenW'(MAX_TAPS - 1)) begin
            cnt_q   <= '0;
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + LenW'(1);
          end
        end
        StIdle: begin
          if (in_valid_i && (sample_i != ntcmon_pkg::FailedSample)) begin
            sample_q <= sample_i;
            len_q    <= len_d;
            state_q  <= StWrite;
          end
        end
        StWrite: begin
          slot_q  <= slot_nxt;
          cnt_q   <= '0;
          sum_q   <= '0;
          state_q <= StSum;
        end
        StSum: begin
          if (cnt_q != '0) begin
            sum_q <= sum_q + SumW'(ram_rdata);
          end
          if (cnt_q == len_q) begin
            div_start_q <= 1'b1;
            state_q     <= StAvgDiv;
          end else begin
            cnt_q <= cnt_q + LenW'(1);
          end
        end
        StAvgDiv: begin
          if (div_done) begin
            avg_q   <= div_quo[15:0];
            state_q <= StRes;
          end
        end
        StRes: begin
          if (avg_q == '0) begin
            raw_q   <= 36'(rceil_q);
            state_q <= StClamp;
          end else if (avg_q >= 16'(ntcmon_pkg::AdcFullScale)) begin
            raw_q   <= '0;
            state_q <= StClamp;
          end else begin
            rawp_q      <= divr_q * (16'(ntcmon_pkg::AdcFullScale) - avg_q);
            div_start_q <= 1'b1;
            state_q     <= StResDiv;
          end
        end
        StResDiv: begin
          if (div_done) begin
            raw_q   <= div_quo[35:0];
            state_q <= StClamp;
          end
        end
        StClamp: begin
          res_q      <= clamp_res;
          ln_start_q <= 1'b1;
          state_q    <= StLnR;
        end
        StLnR: begin
          if (ln_done) begin
            lnr_q      <= ln_res;
            ln_start_q <= 1'b1;
            state_q    <= StLnR0;
          end
        end
        StLnR0: begin
          if (ln_done) begin
            d_q     <= $signed({1'b0, lnr_q}) - $signed({1'b0, ln_res});
            b100_q  <= 21'(beta_q) * 21'd100;
            state_q <= StFx1;
          end
        end
        StFx1: begin
          numa_q  <= b100_q * tnom_q;
          cd_q    <= $signed({1'b0, tnom_q}) * d_q;
          state_q <= StFx2;
        end
        StFx2: begin
          num_q   <= {numa_q, 16'b0};
          den_q   <= cd_q + $signed({2'b00, b100_q, 16'b0});
          state_q <= StFx3;
        end
        StFx3: begin
          if (den_q[38] || (den_q == '0)) begin
            tmp_q   <= 8'd255;
            state_q <= StFin;
          end else begin
            zd_q    <= 53'(den_q[37:0]) * 53'(ntcmon_pkg::ZeroPointCk);
            fifty_q <= 43'(den_q[37:0]) * 43'd50;
            hund_q  <= 44'(den_q[37:0]) * 44'd100;
            state_q <= StFx4;
          end
        end
        StFx4: begin
          q_q     <= $signed({1'b0, num_q}) - $signed({1'b0, zd_q});
          state_q <= StFx5;
        end
        StFx5: begin
          if (q_q[53]) begin
            tmp_q   <= '0;
            state_q <= StFin;
          end else begin
            tdvd_q      <= q_q[52:0] + 53'(fifty_q);
            div_start_q <= 1'b1;
            state_q     <= StTDiv;
          end
        end
        StTDiv: begin
          if (div_done) begin
            tmp_q   <= (div_quo[Dw-1:8] != '0) ? 8'd255 : div_quo[7:0];
            state_q <= StFin;
          end
        end
        StFin: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_avg_q   <= avg_q;
            out_res_q   <= res_q;
            out_tmp_q   <= tmp_q;
            out_over_q  <= (tmp_q > limit_q);
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_sample_o  = out_avg_q;
  assign resistance_ohms_o = out_res_q;
  assign temperature_o     = out_tmp_q;
  assign over_temp_o       = out_over_q;

endmodule

// ===== design/ntcmon_chk.sv =====
`include "ntc_thermistor_temperature_monitor_unit_macros.svh"

module ntcmon_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] sample_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] average_sample_o,
  input logic [19:0] resistance_ohms_o,
  input logic [7:0]  temperature_o,
  input logic        over_temp_o
);

  `NTC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `NTC_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(average_sample_o) && $stable(resistance_ohms_o) && $stable(temperature_o) && $stable(over_temp_o))
  `NTC_ASSERT_NXT(a_busy_after_sample, in_valid_i && in_ready_o && (sample_i != ntcmon_pkg::FailedSample), !in_ready_o)
  `NTC_ASSERT_IMP(a_res_nonzero, out_valid_o, resistance_ohms_o != '0)
  `NTC_ASSERT_IMP(a_over_needs_temp, out_valid_o && over_temp_o, temperature_o != '0)

endmodule

bind ntc_thermistor_temperature_monitor_unit ntcmon_chk u_ntcmon_chk (.*);
